// ===== hw/rtl/huffman_bit_decoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman bit decoder
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_BIT_DECODER_TOP_ASSERT_SVH
`define HUFFMAN_BIT_DECODER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define HBD_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HBD_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/hbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbd_pkg
// Types, constants and helper functions shared by the Huffman bit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hbd_pkg;

  localparam int NODE_COUNT  = 512;
  localparam int SYMBOL_BITS = 8;
  localparam int ADDR_W      = $clog2(NODE_COUNT);
  localparam int IDX_W       = 9;
  localparam int SYM_W       = 8;
  localparam int ACT_W       = 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 9;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DEPTH   = 2;
  localparam int OPTR_W      = $clog2(OUT_DEPTH);
  localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

  localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DECODE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ROOT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROOT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP  = 4'd1;

  localparam logic [31:0] SYM_MASK        = 32'((64'd1 << SYMBOL_BITS) - 64'd1);
  localparam logic [31:0] UNDERSCORE_CODE = 32'h5F;
  localparam logic [31:0] SPACE_CODE      = 32'h20;

  typedef struct packed {
    logic                   leaf;
    logic [SYMBOL_BITS-1:0] sym;
    logic [IDX_W-1:0]       left;
    logic [IDX_W-1:0]       right;
  } node_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] node_index;
    logic             node_is_leaf;
    logic [SYM_W-1:0] node_symbol;
    logic [IDX_W-1:0] left_index;
    logic [IDX_W-1:0] right_index;
    logic             code_bit;
  } in_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    node_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic             push;
    logic [SYM_W-1:0] symbol;
  } res_t;

  function automatic logic idx_oob(input logic [IDX_W-1:0] i);
    return (32'(i) >= 32'(NODE_COUNT));
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] i);
    return ADDR_W'(i);
  endfunction

  function automatic logic [SYM_W-1:0] emit_value(input logic [SYMBOL_BITS-1:0] s,
                                                  input logic map_us);
    logic [31:0] v;
    v = 32'(s);
    if (map_us && (v == UNDERSCORE_CODE))
      v = SPACE_CODE & SYM_MASK;
    return v[SYM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hbd_node_ram.sv =====
// ----------------------------------------------------------------------------
// hbd_node_ram
// Node table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_node_ram (
  input  wire logic             clk,
  input  wire hbd_pkg::ram_req_t req,
  output hbd_pkg::node_t         rd_data
);
  import hbd_pkg::*;

  node_t mem [NODE_COUNT];
  node_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/hbd_walk.sv =====
// ----------------------------------------------------------------------------
// hbd_walk
// Tree walk control: node writes, code bit steps, root return and config.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_walk (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire hbd_pkg::in_item_t                in_item,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hbd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output hbd_pkg::ram_req_t                     ram_req,
  input  wire hbd_pkg::node_t                   ram_rd_data,
  input  wire logic [hbd_pkg::OCNT_W-1:0]       out_cnt,
  output hbd_pkg::res_t                         res
);
  import hbd_pkg::*;

  // outcome kinds of a decode, held in the s2 registers
  localparam logic [1:0] K_EMIT    = 2'd0;
  localparam logic [1:0] K_RESOLVE = 2'd1;
  localparam logic [1:0] K_ROOT    = 2'd2;

  logic [IDX_W-1:0]       root_r, root_nxt;
  logic                   map_r, map_nxt;
  logic [IDX_W-1:0]       cur_r, cur_nxt;
  node_t                  cur_ent_r, cur_ent_nxt;
  node_t                  root_ent_r, root_ent_nxt;
  logic                   s2_v_r, s2_v_nxt;
  logic [1:0]             s2_kind_r, s2_kind_nxt;
  logic [SYMBOL_BITS-1:0] s2_sym_r, s2_sym_nxt;
  logic [IDX_W-1:0]       s2_next_r, s2_next_nxt;
  logic                   rfs_rd_r, rfs_rd_nxt;
  logic                   rfs_ld_r, rfs_ld_nxt;

  logic             acc;
  logic [IDX_W-1:0] child;
  node_t            wnode;

  assign cfg_ready = 1'b1;
  assign in_tready = !s2_v_r && !rfs_rd_r && !rfs_ld_r &&
                     (out_cnt < OCNT_W'(OUT_DEPTH));
  assign acc   = in_tvalid && in_tready;
  assign child = in_item.code_bit ? cur_ent_r.right : cur_ent_r.left;

  always_comb begin
    wnode.leaf  = in_item.node_is_leaf;
    wnode.sym   = SYMBOL_BITS'(in_item.node_symbol);
    wnode.left  = in_item.left_index;
    wnode.right = in_item.right_index;
  end

  always_comb begin
    root_nxt     = root_r;
    map_nxt      = map_r;
    cur_nxt      = cur_r;
    cur_ent_nxt  = cur_ent_r;
    root_ent_nxt = root_ent_r;
    s2_v_nxt     = 1'b0;
    s2_kind_nxt  = s2_kind_r;
    s2_sym_nxt   = s2_sym_r;
    s2_next_nxt  = s2_next_r;
    rfs_rd_nxt   = 1'b0;
    rfs_ld_nxt   = rfs_rd_r;
    ram_req      = '0;
    res.push     = 1'b0;
    res.symbol   = emit_value(s2_sym_r, map_r);

    // resolve the decode issued last cycle
    if (s2_v_r) begin
      unique case (s2_kind_r)
        K_EMIT: begin
          res.push    = 1'b1;
          cur_nxt     = root_r;
          cur_ent_nxt = root_ent_r;
        end
        K_RESOLVE: begin
          if (ram_rd_data.leaf) begin
            res.push    = 1'b1;
            res.symbol  = emit_value(ram_rd_data.sym, map_r);
            cur_nxt     = root_r;
            cur_ent_nxt = root_ent_r;
          end else begin
            cur_nxt     = s2_next_r;
            cur_ent_nxt = ram_rd_data;
          end
        end
        K_ROOT: begin
          cur_nxt     = root_r;
          cur_ent_nxt = root_ent_r;
        end
        default: ;
      endcase
    end

    if (acc) begin
      unique case (in_item.action)
        ACT_WRITE: begin
          if (!idx_oob(in_item.node_index)) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = to_addr(in_item.node_index);
            ram_req.wdata = wnode;
            // keep the cached entries coherent with the table
            if (in_item.node_index == root_r) root_ent_nxt = wnode;
            if (in_item.node_index == cur_r)  cur_ent_nxt  = wnode;
          end
        end
        ACT_DECODE: begin
          s2_v_nxt = 1'b1;
          if (idx_oob(cur_r)) begin
            s2_kind_nxt = K_ROOT;
          end else if (cur_ent_r.leaf) begin
            s2_kind_nxt = K_EMIT;
            s2_sym_nxt  = cur_ent_r.sym;
          end else if (idx_oob(child)) begin
            s2_kind_nxt = K_ROOT;
          end else begin
            s2_kind_nxt   = K_RESOLVE;
            s2_next_nxt   = child;
            ram_req.re    = 1'b1;
            ram_req.raddr = to_addr(child);
          end
        end
        ACT_ROOT: begin
          cur_nxt     = root_r;
          cur_ent_nxt = root_ent_r;
        end
        default: ;
      endcase
    end

    // reload the root entry after the root register moves
    if (rfs_rd_r) begin
      ram_req.re    = 1'b1;
      ram_req.raddr = to_addr(root_r);
    end
    if (rfs_ld_r) begin
      root_ent_nxt = ram_rd_data;
      cur_ent_nxt  = ram_rd_data;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROOT: begin
          root_nxt   = cfg_data;
          cur_nxt    = cfg_data;
          rfs_rd_nxt = 1'b1;
        end
        REG_MAP: map_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r   <= '0;
      map_r    <= 1'b1;
      cur_r    <= '0;
      s2_v_r   <= 1'b0;
      rfs_rd_r <= 1'b0;
      rfs_ld_r <= 1'b0;
    end else begin
      root_r   <= root_nxt;
      map_r    <= map_nxt;
      cur_r    <= cur_nxt;
      s2_v_r   <= s2_v_nxt;
      rfs_rd_r <= rfs_rd_nxt;
      rfs_ld_r <= rfs_ld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_ent_r  <= cur_ent_nxt;
    root_ent_r <= root_ent_nxt;
    s2_kind_r  <= s2_kind_nxt;
    s2_sym_r   <= s2_sym_nxt;
    s2_next_r  <= s2_next_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hbd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// hbd_out_fifo
// Two-entry result queue between the walk and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_out_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hbd_pkg::res_t                 res,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [hbd_pkg::SYM_W-1:0]          out_tdata,
  output logic [hbd_pkg::OCNT_W-1:0]         cnt
);
  import hbd_pkg::*;

  logic [SYM_W-1:0]  buf_r [OUT_DEPTH];
  logic [OPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = buf_r[rd_ptr_r];
  assign cnt        = cnt_r;
  assign pop        = out_tvalid && out_tready;

  always_comb begin
    wr_ptr_nxt = res.push ? wr_ptr_r + OPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + OPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + OCNT_W'(res.push) - OCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) begin
      buf_r[wr_ptr_r] <= res.symbol;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/huffman_bit_decoder_top.sv =====
// ----------------------------------------------------------------------------
// huffman_bit_decoder_top
// Huffman tree-walk decoder with the node table held in block RAM.
//
// Channel | Dir | Handshake             | Payload
// in_     | in  | in_tvalid/in_tready   | tuser: action; tdata: node fields, code bit
// out_    | out | out_tvalid/out_tready | tdata: decoded symbol
// cfg_    | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A decode of an internal node reads the node table entry of the child chosen
// by the code bit; input stalls while each decode resolves.
// Current and root node entries sit in registers; each bit needs at most one read.
// Writing REG_ROOT blocks input while the root entry is read and reloaded.
// Results queue in a two-entry buffer; input also stalls while it is full.
// Reset is synchronous; the node table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_bit_decoder_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [1:0] action
  input  wire logic [hbd_pkg::ACT_W-1:0]           in_tuser,
  // [8:0] node_index, [9] node_is_leaf, [17:10] node_symbol,
  // [26:18] left_index, [35:27] right_index, [36] code_bit, [39:37] zero
  input  wire logic [hbd_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [7:0] symbol
  output logic [hbd_pkg::SYM_W-1:0]                out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [hbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [hbd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hbd_pkg::*;

  in_item_t          in_item;
  ram_req_t          ram_req;
  node_t             ram_rd_data;
  res_t              res;
  logic [OCNT_W-1:0] out_cnt;

  always_comb begin
    in_item.action       = in_tuser;
    in_item.node_index   = in_tdata[8:0];
    in_item.node_is_leaf = in_tdata[9];
    in_item.node_symbol  = in_tdata[17:10];
    in_item.left_index   = in_tdata[26:18];
    in_item.right_index  = in_tdata[35:27];
    in_item.code_bit     = in_tdata[36];
  end

  hbd_walk u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_item     (in_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .out_cnt     (out_cnt),
    .res         (res)
  );

  hbd_node_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  hbd_out_fifo u_ofifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cnt        (out_cnt)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/hbd_checker.sv =====
// ----------------------------------------------------------------------------
// hbd_checker
// Port-level checks on the Huffman bit decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_bit_decoder_top_assert.svh"

module hbd_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic [hbd_pkg::ACT_W-1:0]           in_tuser,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [hbd_pkg::SYM_W-1:0]           out_tdata,
  input wire logic                                cfg_valid,
  input wire logic                                cfg_ready,
  input wire logic [hbd_pkg::CFG_IDX_W-1:0]       cfg_index
);
  import hbd_pkg::*;

  logic in_acc;
  logic cfg_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign cfg_acc = cfg_valid && cfg_ready;

  // a stalled result keeps its value
  `HBD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // every decode holds off input while it resolves
  `HBD_ASSERT_NXT(a_dec_two_cycles, in_acc && (in_tuser == ACT_DECODE), !in_tready, "input taken during decode lookup")

  // only decodes produce results
  `HBD_ASSERT_NXT(a_no_spurious, in_acc && (in_tuser != ACT_DECODE) && !out_tvalid, !out_tvalid, "result from a non-decode transaction")

  // root change reloads the root entry before new input
  `HBD_ASSERT_NXT(a_root_reload, cfg_acc && (cfg_index == REG_ROOT), !in_tready, "input taken during root reload")

endmodule

bind huffman_bit_decoder_top hbd_checker u_hbd_checker (.*);

`default_nettype wire
